/* hdl/usart_tick_model_assert.svh */
// Assertion macros shared by the serial port tick model RTL.
`ifndef USART_TICK_MODEL_ASSERT_SVH
`define USART_TICK_MODEL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define UT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ut_pkg.sv */
// Types and constants of the serial port tick model.
package ut_pkg;

  localparam int ITEM_W = 24;
  localparam int RES_W  = 24;

  localparam logic [15:0] STEP_FAST = 16'd40;
  localparam logic [15:0] STEP_SLOW = 16'd160;

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_TWO   = 2'd2;
  localparam logic [1:0] FILL_BAD   = 2'd3;

  localparam logic [1:0] CFG_BAUD_DIVISOR = 2'd0;
  localparam logic [1:0] CFG_HIGH_SPEED   = 2'd1;
  localparam logic [1:0] CFG_LINK_PRESENT = 2'd2;

  typedef enum logic [1:0] {
    LINK_CLOSED = 2'd0,
    LINK_OPEN   = 2'd1,
    LINK_FAILED = 2'd2
  } ut_link_t;

  typedef struct packed {
    logic [7:0] baud_divisor;
    logic       high_speed;
    logic       link_present;
  } ut_cfg_t;

  typedef struct packed {
    logic       port_enable;
    logic       receive_enable;
    logic       status_written;
    logic       tx_write;
    logic [7:0] tx_data;
    logic       rx_read;
    logic       rx_pin_input;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } ut_item_t;

  typedef struct packed {
    logic [7:0] rx_value;
    logic       rx_accepted;
    logic       rx_flag;
    logic       tx_flag;
    logic       tx_empty;
    logic       overrun;
    logic       tx_out_valid;
    logic [7:0] tx_out_byte;
  } ut_result_t;

  typedef struct packed {
    logic [15:0] frame_ticks;
    logic [7:0]  rx_head;
    logic [7:0]  rx_second;
    logic [1:0]  rx_fill;
    logic        overrun_bit;
    logic [7:0]  tx_pending;
    logic        tx_empty_bit;
    logic        tx_flag_bit;
    logic        rx_flag_bit;
    ut_link_t    link;
  } ut_state_t;

endpackage

/* hdl/ut_step.sv */
// Next-state and result logic for one tick of the serial port.
module ut_step import ut_pkg::*; (
  input  ut_state_t  st,
  input  ut_cfg_t    cfg,
  input  ut_item_t   item,
  output ut_state_t  st_nxt,
  output ut_result_t res
);

  always_comb begin
    ut_state_t   s;
    logic [15:0] cnt;
    logic [15:0] step;
    logic [15:0] limit;
    logic        acc;
    logic        sent;
    logic [7:0]  sent_byte;

    s         = st;
    acc       = 1'b0;
    sent      = 1'b0;
    sent_byte = 8'h00;

    // enable edge opens or fails the link; disable closes only an open one
    if (item.port_enable) begin
      if (s.link == LINK_CLOSED) begin
        s.link         = cfg.link_present ? LINK_OPEN : LINK_FAILED;
        s.tx_empty_bit = 1'b1;
        s.tx_flag_bit  = 1'b1;
      end
    end else if (s.link == LINK_OPEN) begin
      s.link = LINK_CLOSED;
    end

    if (item.tx_write) begin
      s.tx_pending   = item.tx_data;
      s.tx_empty_bit = 1'b0;
      s.tx_flag_bit  = 1'b0;
    end

    if (item.status_written && !item.receive_enable) begin
      s.overrun_bit = 1'b0;
      s.frame_ticks = 16'h0000;
    end

    if (item.rx_read) begin
      if (s.rx_fill == FILL_ONE) begin
        s.rx_head     = 8'h00;
        s.rx_flag_bit = 1'b0;
        s.rx_fill     = FILL_EMPTY;
      end else if (s.rx_fill == FILL_TWO) begin
        s.rx_head   = s.rx_second;
        s.rx_second = 8'h00;
        s.rx_fill   = FILL_ONE;
      end
    end

    cnt           = s.frame_ticks + 16'd1;
    step          = cfg.high_speed ? STEP_FAST : STEP_SLOW;
    limit         = ({8'h00, cfg.baud_divisor} + 16'd1) * step;
    s.frame_ticks = cnt;

    if (cnt >= limit) begin
      s.frame_ticks = 16'h0000;
      if (s.link != LINK_CLOSED && cfg.link_present && item.rx_pin_input && item.rx_valid) begin
        acc = 1'b1;
        if (item.receive_enable && !s.overrun_bit) begin
          if (s.rx_fill == FILL_EMPTY) begin
            s.rx_head   = item.rx_byte;
            s.rx_second = 8'h00;
            s.rx_fill   = FILL_ONE;
          end else if (s.rx_fill == FILL_ONE) begin
            s.rx_second = item.rx_byte;
            s.rx_fill   = FILL_TWO;
          end else begin
            s.overrun_bit = 1'b1;
          end
        end
        s.rx_flag_bit = 1'b1;
      end
      if (!s.tx_empty_bit) begin
        if (s.link == LINK_OPEN) begin
          sent      = 1'b1;
          sent_byte = s.tx_pending;
        end
        s.tx_empty_bit = 1'b1;
        s.tx_flag_bit  = 1'b1;
      end
    end

    st_nxt           = s;
    res.rx_value     = s.rx_head;
    res.rx_accepted  = acc;
    res.rx_flag      = s.rx_flag_bit;
    res.tx_flag      = s.tx_flag_bit;
    res.tx_empty     = s.tx_empty_bit;
    res.overrun      = s.overrun_bit;
    res.tx_out_valid = sent;
    res.tx_out_byte  = sent_byte;
  end

endmodule

/* hdl/ut_outbuf.sv */
// Result register with a skid stage so the input side keeps moving.
module ut_outbuf import ut_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ut_result_t push_data,
  output logic       can_push,
  output logic       out_valid,
  input  logic       out_ready,
  output ut_result_t out_data,
  output logic       skid_valid
);

  logic       out_v_r, out_v_nxt;
  logic       skid_v_r, skid_v_nxt;
  ut_result_t out_d_r, out_d_nxt;
  ut_result_t skid_d_r, skid_d_nxt;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (out_v_r && out_ready) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
    // push only happens with the skid stage empty
    if (push) begin
      if (!out_v_r || out_ready) begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign can_push   = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;
  assign skid_valid = skid_v_r;

endmodule

/* hdl/usart_tick_model.sv */
// Top level of the serial port tick model: config, tick state and result buffer.
//
//  channel | ports                          | item
//  --------+--------------------------------+-------------------------------
//  cfg     | cfg_we, cfg_index, cfg_data    | register write, no handshake
//  in      | in_tvalid/in_tready/in_tdata   | one instruction tick
//  out     | out_tvalid/out_tready/out_tdata| one result per tick
//
// Every tick is worked in the cycle it is accepted: the step logic reads the
// tick state registers and writes them back, one item per clock while
// in_tready is high. The result is registered in the output register, or in
// the skid stage while the output is stalled. The skid stage holds one more
// result, so in_tready drops only when both are full under a stalled out_tready.
// Synchronous active-low reset: link closed, queue empty, tx_empty set,
// divisor 0, normal speed, line attached.
module usart_tick_model import ut_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  // port_enable, receive_enable, status_written, tx_write, tx_data[7:0],
  // rx_read, rx_pin_input, rx_valid, rx_byte[7:0], zero pad
  input  logic [ITEM_W-1:0] in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // rx_value[7:0], rx_accepted, rx_flag, tx_flag, tx_empty, overrun,
  // tx_out_valid, tx_out_byte[7:0], zero pad
  output logic [RES_W-1:0]  out_tdata
);

  `include "usart_tick_model_assert.svh"

  ut_cfg_t    cfg_r;
  ut_state_t  st_r;
  ut_state_t  st_nxt;
  ut_item_t   item;
  ut_result_t res;
  ut_result_t out_res;
  logic       accept;
  logic       skid_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baud_divisor <= 8'h00;
      cfg_r.high_speed   <= 1'b0;
      cfg_r.link_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BAUD_DIVISOR: cfg_r.baud_divisor <= cfg_data;
        CFG_HIGH_SPEED:   cfg_r.high_speed   <= cfg_data[0];
        CFG_LINK_PRESENT: cfg_r.link_present <= cfg_data[0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // unpack the tick
  assign item.port_enable    = in_tdata[0];
  assign item.receive_enable = in_tdata[1];
  assign item.status_written = in_tdata[2];
  assign item.tx_write       = in_tdata[3];
  assign item.tx_data        = in_tdata[11:4];
  assign item.rx_read        = in_tdata[12];
  assign item.rx_pin_input   = in_tdata[13];
  assign item.rx_valid       = in_tdata[14];
  assign item.rx_byte        = in_tdata[22:15];

  assign accept = in_tvalid && in_tready;

  ut_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // tick state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.frame_ticks  <= 16'h0000;
      st_r.rx_head      <= 8'h00;
      st_r.rx_second    <= 8'h00;
      st_r.rx_fill      <= FILL_EMPTY;
      st_r.overrun_bit  <= 1'b0;
      st_r.tx_pending   <= 8'h00;
      st_r.tx_empty_bit <= 1'b1;
      st_r.tx_flag_bit  <= 1'b0;
      st_r.rx_flag_bit  <= 1'b0;
      st_r.link         <= LINK_CLOSED;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  ut_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .can_push   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res),
    .skid_valid (skid_valid)
  );

  assign out_tdata = {2'b00, out_res.tx_out_byte, out_res.tx_out_valid, out_res.overrun,
                      out_res.tx_empty, out_res.tx_flag, out_res.rx_flag,
                      out_res.rx_accepted, out_res.rx_value};

  `UT_ASSERT_NOW(a_skid_behind_out, skid_valid, out_tvalid, "skid holds a result ahead of output")
  `UT_ASSERT_NOW(a_fill_legal, 1'b1, st_r.rx_fill != FILL_BAD, "receive queue fill out of range")
  `UT_ASSERT_NEXT(a_failed_sticks, st_r.link == LINK_FAILED, st_r.link == LINK_FAILED, "failed link left failed state")
  `UT_ASSERT_NOW(a_sent_needs_empty, out_tvalid && out_res.tx_out_valid, out_res.tx_empty, "byte sent without tx_empty set")

endmodule

/* bench/usart_tick_checker.sv */
// Checker for the serial port tick model: predicts every tick result and compares it.
`timescale 1ns / 1ps

module usart_tick_checker import ut_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [ITEM_W-1:0] in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [RES_W-1:0]  out_tdata,
  output int                errors,
  output int                outstanding,
  output int                n_results,
  output int                n_taken,
  output int                n_sent,
  output int                n_overruns
);

  ut_cfg_t    regs;
  ut_state_t  st;
  ut_result_t tick_results[$];
  int         err_cnt   = 0;
  int         res_cnt   = 0;
  int         taken_cnt = 0;
  int         sent_cnt  = 0;
  int         ovr_cnt   = 0;

  function automatic void reset_model();
    regs.baud_divisor = 8'd0;
    regs.high_speed   = 1'b0;
    regs.link_present = 1'b1;
    st                = '0;
    st.tx_empty_bit   = 1'b1;
    st.link           = LINK_CLOSED;
  endfunction

  // tdata layouts, lowest bit first
  function automatic ut_item_t unpack_tick(input logic [ITEM_W-1:0] d);
    ut_item_t t;
    t.port_enable    = d[0];
    t.receive_enable = d[1];
    t.status_written = d[2];
    t.tx_write       = d[3];
    t.tx_data        = d[11:4];
    t.rx_read        = d[12];
    t.rx_pin_input   = d[13];
    t.rx_valid       = d[14];
    t.rx_byte        = d[22:15];
    return t;
  endfunction

  function automatic ut_result_t unpack_result(input logic [RES_W-1:0] d);
    ut_result_t r;
    r.rx_value     = d[7:0];
    r.rx_accepted  = d[8];
    r.rx_flag      = d[9];
    r.tx_flag      = d[10];
    r.tx_empty     = d[11];
    r.overrun      = d[12];
    r.tx_out_valid = d[13];
    r.tx_out_byte  = d[21:14];
    return r;
  endfunction

  // One instruction tick of the port.
  function automatic ut_result_t step_tick(input ut_item_t t);
    ut_result_t r;
    int         cnt;
    int         lim;
    r = '0;
    // enable edge opens or fails the link; a failed link stays failed
    if (t.port_enable) begin
      if (st.link == LINK_CLOSED) begin
        st.link         = regs.link_present ? LINK_OPEN : LINK_FAILED;
        st.tx_empty_bit = 1'b1;
        st.tx_flag_bit  = 1'b1;
      end
    end else if (st.link == LINK_OPEN) begin
      st.link = LINK_CLOSED;
    end
    if (t.tx_write) begin
      st.tx_pending   = t.tx_data;
      st.tx_empty_bit = 1'b0;
      st.tx_flag_bit  = 1'b0;
    end
    if (t.status_written && !t.receive_enable) begin
      st.overrun_bit = 1'b0;
      st.frame_ticks = 16'd0;
    end
    // a fill of three reads as empty
    if (t.rx_read) begin
      if (st.rx_fill == FILL_ONE) begin
        st.rx_head     = 8'd0;
        st.rx_flag_bit = 1'b0;
        st.rx_fill     = FILL_EMPTY;
      end else if (st.rx_fill == FILL_TWO) begin
        st.rx_head   = st.rx_second;
        st.rx_second = 8'd0;
        st.rx_fill   = FILL_ONE;
      end
    end
    st.frame_ticks = st.frame_ticks + 16'd1;
    cnt = st.frame_ticks;
    lim = (int'(regs.baud_divisor) + 1) * int'(regs.high_speed ? STEP_FAST : STEP_SLOW);
    if (cnt >= lim) begin
      st.frame_ticks = 16'd0;
      if (st.link != LINK_CLOSED && regs.link_present && t.rx_pin_input && t.rx_valid) begin
        r.rx_accepted = 1'b1;
        if (t.receive_enable && !st.overrun_bit) begin
          case (st.rx_fill)
            FILL_EMPTY: begin
              st.rx_head   = t.rx_byte;
              st.rx_second = 8'd0;
              st.rx_fill   = FILL_ONE;
            end
            FILL_ONE: begin
              st.rx_second = t.rx_byte;
              st.rx_fill   = FILL_TWO;
            end
            default: begin
              st.overrun_bit = 1'b1;
              ovr_cnt++;
            end
          endcase
        end
        st.rx_flag_bit = 1'b1;
      end
      if (!st.tx_empty_bit) begin
        if (st.link == LINK_OPEN) begin
          r.tx_out_valid = 1'b1;
          r.tx_out_byte  = st.tx_pending;
        end
        st.tx_empty_bit = 1'b1;
        st.tx_flag_bit  = 1'b1;
      end
    end
    r.rx_value = st.rx_head;
    r.rx_flag  = st.rx_flag_bit;
    r.tx_flag  = st.tx_flag_bit;
    r.tx_empty = st.tx_empty_bit;
    r.overrun  = st.overrun_bit;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    ut_result_t want;
    ut_result_t got;
    if (!rst_n) begin
      reset_model();
      tick_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BAUD_DIVISOR: regs.baud_divisor = cfg_data;
          CFG_HIGH_SPEED:   regs.high_speed   = cfg_data[0];
          CFG_LINK_PRESENT: regs.link_present = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        tick_results.push_back(step_tick(unpack_tick(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = unpack_result(out_tdata);
        if (tick_results.size() == 0) begin
          $error("result 0x%0h with no tick waiting", out_tdata);
          err_cnt++;
        end else begin
          want = tick_results.pop_front();
          res_cnt++;
          if (want.rx_accepted)  taken_cnt++;
          if (want.tx_out_valid) sent_cnt++;
          check_field("rx_value",     want.rx_value,     got.rx_value);
          check_field("rx_accepted",  want.rx_accepted,  got.rx_accepted);
          check_field("rx_flag",      want.rx_flag,      got.rx_flag);
          check_field("tx_flag",      want.tx_flag,      got.tx_flag);
          check_field("tx_empty",     want.tx_empty,     got.tx_empty);
          check_field("overrun",      want.overrun,      got.overrun);
          check_field("tx_out_valid", want.tx_out_valid, got.tx_out_valid);
          check_field("tx_out_byte",  want.tx_out_byte,  got.tx_out_byte);
        end
      end
    end
    errors      <= err_cnt;
    outstanding <= tick_results.size();
    n_results   <= res_cnt;
    n_taken     <= taken_cnt;
    n_sent      <= sent_cnt;
    n_overruns  <= ovr_cnt;
  end

endmodule

/* bench/tb.sv */
// Testbench top for the serial port tick model: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
  import ut_pkg::*;

  // Longest quiet stretch in a good run is the receiver hold-off below plus
  // a drain between phases; the watchdog allows many times that.
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [ITEM_W-1:0] in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [RES_W-1:0]  out_tdata;

  int errors, outstanding, n_results, n_taken, n_sent, n_overruns;
  int settings    = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit hold_req    = 1'b0;

  usart_tick_model dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  usart_tick_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .outstanding (outstanding),
    .n_results   (n_results),
    .n_taken     (n_taken),
    .n_sent      (n_sent),
    .n_overruns  (n_overruns)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: windows of always-ready, random and periodic stalls, plus one
  // long hold-off once requested so the block backs up into its input.
  initial begin : receiver
    int hold_left;
    int win_left;
    int mode;
    int phase;
    bit held;
    hold_left = 0;
    win_left  = 0;
    mode      = 0;
    phase     = 0;
    held      = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (win_left == 0) begin
          mode     = $urandom_range(0, 3);
          win_left = $urandom_range(16, 96);
        end
        win_left--;
        phase++;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (phase % 5 != 0);
        endcase
      end
    end
  end

  // tdata layout, lowest bit first; bit 23 stays zero
  function automatic logic [ITEM_W-1:0] pack_tick(input ut_item_t t);
    logic [ITEM_W-1:0] d;
    d        = '0;
    d[0]     = t.port_enable;
    d[1]     = t.receive_enable;
    d[2]     = t.status_written;
    d[3]     = t.tx_write;
    d[11:4]  = t.tx_data;
    d[12]    = t.rx_read;
    d[13]    = t.rx_pin_input;
    d[14]    = t.rx_valid;
    d[22:15] = t.rx_byte;
    return d;
  endfunction

  function automatic ut_item_t mk_tick(input int pe, input int cren, input int sw,
                                       input int txw, input logic [7:0] txd,
                                       input int rd, input int pin, input int rxv,
                                       input logic [7:0] rxb);
    ut_item_t t;
    t.port_enable    = pe[0];
    t.receive_enable = cren[0];
    t.status_written = sw[0];
    t.tx_write       = txw[0];
    t.tx_data        = txd;
    t.rx_read        = rd[0];
    t.rx_pin_input   = pin[0];
    t.rx_valid       = rxv[0];
    t.rx_byte        = rxb;
    return t;
  endfunction

  // Mostly plausible software traffic, one in ten ticks pure noise.
  // keep_count stops status writes from restarting the frame counter.
  function automatic ut_item_t rand_tick(input int en_pct, input int read_pct,
                                         input bit keep_count);
    ut_item_t    t;
    logic [31:0] rnd;
    if ($urandom_range(0, 9) == 0) begin
      rnd = $urandom;
      t   = rnd[22:0];
    end else begin
      t.port_enable    = ($urandom_range(0, 99) < en_pct);
      t.receive_enable = ($urandom_range(0, 99) < 85);
      t.status_written = ($urandom_range(0, 99) < 3);
      t.tx_write       = ($urandom_range(0, 99) < 6);
      rnd              = $urandom;
      t.tx_data        = rnd[7:0];
      t.rx_read        = ($urandom_range(0, 99) < read_pct);
      t.rx_pin_input   = ($urandom_range(0, 99) < 92);
      t.rx_valid       = ($urandom_range(0, 99) < 60);
      rnd              = $urandom;
      t.rx_byte        = rnd[7:0];
    end
    if (en_pct >= 100) t.port_enable = 1'b1;
    if (keep_count && t.status_written) t.receive_enable = 1'b1;
    return t;
  endfunction

  task automatic send_tick(input ut_item_t t);
    in_tvalid <= 1'b1;
    in_tdata  <= pack_tick(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Sender works in bursts with random gaps; about a third of bursts follow
  // back to back.
  task automatic offer(input ut_item_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_tick(t);
  endtask

  // Wait out every expected result, then let the result stage settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] div, input logic hs, input logic lp);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BAUD_DIVISOR;
    cfg_data  <= div;
    @(posedge clk);
    cfg_index <= CFG_HIGH_SPEED;
    cfg_data  <= {7'd0, hs};
    @(posedge clk);
    cfg_index <= CFG_LINK_PRESENT;
    cfg_data  <= {7'd0, lp};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Filler ticks so that t lands on a frame fire at the 40-tick period.
  // restart begins with a status write that clears the counter.
  task automatic frame_tick(input ut_item_t t, input bit restart);
    ut_item_t fill;
    fill                = '0;
    fill.port_enable    = t.port_enable;
    fill.receive_enable = 1'b1;
    if (restart) begin
      fill.status_written = 1'b1;
      fill.receive_enable = 1'b0;
      offer(fill);
      fill.status_written = 1'b0;
      fill.receive_enable = 1'b1;
    end
    repeat (restart ? 38 : 39) offer(fill);
    offer(t);
  endtask

  // Random phase; ends on a tick with the port enabled so an open link
  // stays open across the next register change.
  task automatic run_phase(input logic [7:0] div, input logic hs, input logic lp,
                           input int n, input int en_pct, input int read_pct,
                           input bit keep_count, input bit pause_mid, input bit squeeze);
    set_config(div, hs, lp);
    if (squeeze) hold_req <= 1'b1;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      offer(rand_tick(en_pct, read_pct, keep_count));
    end
    offer(mk_tick(1, 1, 0, 0, 8'h00, 0, 0, 0, 8'h00));
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_BAUD_DIVISOR;
    cfg_data  <= 8'd0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 40-tick frames, line attached
    set_config(8'd0, 1'b1, 1'b1);
    offer(mk_tick(0, 0, 0, 0, 8'h00, 0, 0, 0, 8'h00));   // port closed, all quiet
    offer(mk_tick(1, 1, 0, 0, 8'h00, 1, 1, 1, 8'hFF));   // enable edge; read of empty queue
    offer(mk_tick(1, 1, 0, 1, 8'hFF, 0, 1, 1, 8'h00));   // tx write
    frame_tick(mk_tick(1, 1, 0, 0, 8'h00, 0, 1, 1, 8'h00), 1'b1);  // first byte in, FF out
    frame_tick(mk_tick(1, 1, 0, 1, 8'h00, 0, 1, 1, 8'hFF), 1'b0);  // second entry, tx at fire
    frame_tick(mk_tick(1, 1, 0, 0, 8'h00, 0, 1, 1, 8'hA5), 1'b0);  // full queue: overrun
    frame_tick(mk_tick(1, 1, 0, 0, 8'h00, 1, 1, 1, 8'h5A), 1'b0);  // read two; overrun blocks
    offer(mk_tick(1, 1, 1, 0, 8'h00, 1, 1, 0, 8'h00));   // status write, cren on; read last
    offer(mk_tick(1, 0, 1, 0, 8'h00, 1, 1, 0, 8'h00));   // status write, cren off: clears
    frame_tick(mk_tick(1, 0, 0, 0, 8'h00, 0, 1, 1, 8'h3C), 1'b1);  // cren off: byte dropped
    frame_tick(mk_tick(1, 1, 0, 0, 8'h00, 0, 0, 1, 8'hC3), 1'b1);  // pin not input
    offer(mk_tick(0, 1, 0, 0, 8'h00, 1, 1, 1, 8'h00));   // disable closes the link
    frame_tick(mk_tick(0, 1, 0, 1, 8'h77, 0, 1, 1, 8'h81), 1'b1);  // closed: nothing moves
    offer(mk_tick(1, 1, 0, 0, 8'h00, 0, 1, 1, 8'h00));   // reopen

    // random phases, failing the link only at the end since it sticks
    run_phase(8'd0, 1'b0, 1'b1, 200, 97,  8, 1'b0, 1'b0, 1'b0);  // reset settings
    run_phase(8'd0, 1'b1, 1'b1, 400, 97,  2, 1'b0, 1'b0, 1'b1);  // fastest, long hold
    run_phase(8'd2, 1'b1, 1'b1, 200, 90,  3, 1'b0, 1'b1, 1'b0);  // pause mid-phase
    run_phase(8'd7, 1'b1, 1'b1, 350, 100, 1, 1'b1, 1'b0, 1'b0);  // 320-tick frames
    run_phase(8'd1, 1'b1, 1'b0, 150, 100, 2, 1'b0, 1'b0, 1'b0);  // line gone, link open
    run_phase(8'd0, 1'b1, 1'b0, 150, 90,  2, 1'b0, 1'b0, 1'b0);  // link fails
    run_phase(8'd0, 1'b1, 1'b1, 200, 95,  2, 1'b0, 1'b0, 1'b0);  // failed link, line back

    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d ticks over %0d register settings: %0d line bytes taken, %0d sent,",
             n_results, settings, n_taken, n_sent);
    $display("%0d overruns; one %0d-cycle receiver hold-off and one sender pause to empty",
             n_overruns, LONG_HOLD);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
